### sv/rsc_pkg.sv
// Shared types and constants for the RPN stack calculator.
// Used by rsc_alu and rpn_stack_calculator; depends on nothing else.
package rsc_pkg;

  localparam int unsigned RSC_STACK_DEPTH = 64;
  localparam int unsigned DATA_W          = 32;

  // Instruction codes carried on the input tuser
  typedef enum logic [2:0] {
    FN_PUSH = 3'd0,
    FN_OUT  = 3'd1,
    FN_ADD  = 3'd2,
    FN_SUB  = 3'd3,
    FN_DIV  = 3'd4,
    FN_MUL  = 3'd5,
    FN_HALT = 3'd6,
    FN_SQRT = 3'd7
  } func_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_ZDIV    = 3'd3,
    ST_NEGROOT = 3'd4,
    ST_HALT    = 3'd5,
    ST_STOPPED = 3'd6
  } status_t;

  // Operations of the shared arithmetic unit
  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  // Request to the arithmetic unit: a is the stack top, b the next entry
  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
  } alu_req_t;

  // Response from the arithmetic unit: done pulses for one cycle
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

### sv/rpn_stack_calculator.sv
// RPN stack calculator: one instruction per transaction, one result each.
// Push, halt, stopped and errors found at once go straight to the response; output and
// negative root follow the top read, zero divisor the second read, and add, subtract,
// multiply, square root and divide wait for rsc_alu and its bit-a-cycle loops.
// One item is in work at a time; the next is taken once the result is loaded.
// Reset (rst_n low, synchronous) empties the stack and clears the stopped flag.
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = rsc_pkg::RSC_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand
  input  logic [2:0]  in_tuser,   // [2:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [2:0] status, [34:3] out_value, [41:35] depth_now
  output logic [0:0]  out_tuser   // [0] out_valid
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_WAIT,
    S_RESP
  } state_t;

  state_t             state_r;
  rsc_pkg::func_t     func_r;
  rsc_pkg::status_t   status_r;
  logic [PW-1:0]      sp_r;
  logic               stopped_r;
  logic [31:0]        a_r;
  logic [31:0]        value_r;
  logic               vflag_r;
  logic               out_tvalid_r;
  logic [47:0]        out_data_r;
  logic               out_user_r;

  logic [31:0]        stack_mem [STACK_DEPTH];
  logic [31:0]        rd_data_r;

  rsc_pkg::func_t     in_func;
  logic               accept;
  logic [PW-1:0]      sp_dec1;
  logic [PW-1:0]      sp_dec2;
  logic [AW-1:0]      top_addr;
  logic [AW-1:0]      next_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  rsc_pkg::alu_req_t  alu_req;
  rsc_pkg::alu_rsp_t  alu_rsp;
  rsc_pkg::alu_op_t   bin_op;

  assign in_func   = rsc_pkg::func_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign sp_dec1   = sp_r - PW'(1);
  assign sp_dec2   = sp_r - PW'(2);
  assign top_addr  = sp_dec1[AW-1:0];
  assign next_addr = sp_dec2[AW-1:0];

  // Map binary instructions onto the unit's operations
  always_comb begin
    case (func_r)
      rsc_pkg::FN_SUB: bin_op = rsc_pkg::ALU_SUB;
      rsc_pkg::FN_MUL: bin_op = rsc_pkg::ALU_MUL;
      rsc_pkg::FN_DIV: bin_op = rsc_pkg::ALU_DIV;
      default:         bin_op = rsc_pkg::ALU_ADD;
    endcase
  end

  // Stack memory ports and unit requests
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = sp_r[AW-1:0];
    wr_data       = in_tdata;
    rd_en         = 1'b0;
    rd_addr       = top_addr;
    alu_req.start = 1'b0;
    alu_req.op    = bin_op;
    alu_req.opa   = a_r;
    alu_req.opb   = rd_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_en = 1'b1;
          if (!stopped_r && in_func == rsc_pkg::FN_PUSH && sp_r < PW'(STACK_DEPTH)) begin
            wr_en = 1'b1;
          end
        end
      end
      S_RDA: begin
        if (func_r == rsc_pkg::FN_SQRT) begin
          alu_req.start = ~rd_data_r[31];
          alu_req.op    = rsc_pkg::ALU_SQRT;
          alu_req.opa   = rd_data_r;
        end else if (func_r != rsc_pkg::FN_OUT) begin
          rd_en   = 1'b1;
          rd_addr = next_addr;
        end
      end
      S_RDB: begin
        alu_req.start = !(func_r == rsc_pkg::FN_DIV && a_r == 32'd0);
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          wr_en   = 1'b1;
          wr_addr = (func_r == rsc_pkg::FN_SQRT) ? top_addr : next_addr;
          wr_data = alu_rsp.result;
        end
      end
      default: begin
      end
    endcase
  end

  // Stack memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  rsc_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // Instruction sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sp_r         <= '0;
      stopped_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r  <= in_func;
            value_r <= '0;
            vflag_r <= 1'b0;
            status_r <= rsc_pkg::ST_OK;
            state_r <= S_RESP;
            if (stopped_r) begin
              status_r <= rsc_pkg::ST_STOPPED;
            end else begin
              case (in_func)
                rsc_pkg::FN_PUSH: begin
                  if (sp_r >= PW'(STACK_DEPTH)) begin
                    status_r  <= rsc_pkg::ST_OVER;
                    stopped_r <= 1'b1;
                  end else begin
                    sp_r <= sp_r + PW'(1);
                  end
                end
                rsc_pkg::FN_HALT: begin
                  status_r  <= rsc_pkg::ST_HALT;
                  stopped_r <= 1'b1;
                end
                rsc_pkg::FN_OUT, rsc_pkg::FN_SQRT: begin
                  if (sp_r == '0) begin
                    status_r  <= rsc_pkg::ST_UNDER;
                    stopped_r <= 1'b1;
                  end else begin
                    state_r <= S_RDA;
                  end
                end
                default: begin
                  if (sp_r < PW'(2)) begin
                    status_r  <= rsc_pkg::ST_UNDER;
                    stopped_r <= 1'b1;
                  end else begin
                    state_r <= S_RDA;
                  end
                end
              endcase
            end
          end
        end
        S_RDA: begin
          a_r <= rd_data_r;
          case (func_r)
            rsc_pkg::FN_OUT: begin
              value_r <= rd_data_r;
              vflag_r <= 1'b1;
              sp_r    <= sp_dec1;
              state_r <= S_RESP;
            end
            rsc_pkg::FN_SQRT: begin
              if (rd_data_r[31]) begin
                status_r  <= rsc_pkg::ST_NEGROOT;
                stopped_r <= 1'b1;
                state_r   <= S_RESP;
              end else begin
                state_r <= S_WAIT;
              end
            end
            default: begin
              state_r <= S_RDB;
            end
          endcase
        end
        S_RDB: begin
          if (func_r == rsc_pkg::FN_DIV && a_r == 32'd0) begin
            status_r  <= rsc_pkg::ST_ZDIV;
            stopped_r <= 1'b1;
            state_r   <= S_RESP;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          // Drop one entry for binary operations once the result is written
          if (alu_rsp.done) begin
            if (func_r != rsc_pkg::FN_SQRT) begin
              sp_r <= sp_dec1;
            end
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          // Load the output register once it is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= {6'd0, 7'(sp_r), value_r, status_r};
            out_user_r   <= vflag_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

endmodule

### sv/rsc_alu.sv
// Shared arithmetic unit: add, subtract, multiply in one step, signed divide
// one quotient bit a cycle and floor square root one root bit a cycle.
// Depends on rsc_pkg for the request and response structs.
module rsc_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  rsc_pkg::alu_req_t req,
  output rsc_pkg::alu_rsp_t rsp
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_SQRT,
    A_FIX
  } astate_t;

  astate_t     state_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] shf_r;
  logic [31:0] dvs_r;
  logic [15:0] root_r;
  logic        neg_r;
  logic [31:0] res_r;
  logic        done_r;

  logic [33:0] min_op;
  logic [33:0] sub_op;
  logic [33:0] diff;
  logic        fits;
  logic [15:0] root_nxt;
  logic [31:0] a_abs;
  logic [31:0] b_abs;
  logic [31:0] prod;

  // Select operands of the shared subtractor for each iteration
  always_comb begin
    case (state_r)
      A_DIV: begin
        min_op = {1'b0, rem_r, shf_r[31]};
        sub_op = {2'b00, dvs_r};
      end
      A_SQRT: begin
        min_op = {rem_r, shf_r[31:30]};
        sub_op = {16'd0, root_r, 2'b01};
      end
      A_FIX: begin
        min_op = '0;
        sub_op = {2'b00, shf_r};
      end
      default: begin
        min_op = '0;
        sub_op = '0;
      end
    endcase
  end

  assign diff     = min_op - sub_op;
  assign fits     = ~diff[33];
  assign root_nxt = {root_r[14:0], fits};

  // Magnitudes and product for the start cycle
  assign a_abs = req.opa[31] ? (~req.opa + 32'd1) : req.opa;
  assign b_abs = req.opb[31] ? (~req.opb + 32'd1) : req.opb;
  assign prod  = req.opa * req.opb;

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        A_IDLE: begin
          if (req.start) begin
            case (req.op)
              rsc_pkg::ALU_ADD: begin
                res_r  <= req.opa + req.opb;
                done_r <= 1'b1;
              end
              rsc_pkg::ALU_SUB: begin
                res_r  <= req.opb - req.opa;
                done_r <= 1'b1;
              end
              rsc_pkg::ALU_MUL: begin
                res_r  <= prod;
                done_r <= 1'b1;
              end
              rsc_pkg::ALU_DIV: begin
                dvs_r   <= a_abs;
                shf_r   <= b_abs;
                rem_r   <= '0;
                neg_r   <= req.opa[31] ^ req.opb[31];
                cnt_r   <= '0;
                state_r <= A_DIV;
              end
              rsc_pkg::ALU_SQRT: begin
                shf_r   <= req.opa;
                rem_r   <= '0;
                root_r  <= '0;
                cnt_r   <= '0;
                state_r <= A_SQRT;
              end
              default: begin
                res_r  <= '0;
                done_r <= 1'b1;
              end
            endcase
          end
        end
        A_DIV: begin
          // Restoring step: shift in the next dividend bit, keep it if it fits
          rem_r <= fits ? diff[31:0] : min_op[31:0];
          shf_r <= {shf_r[30:0], fits};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= A_FIX;
          end
        end
        A_FIX: begin
          // Apply the quotient sign through the subtractor
          res_r   <= neg_r ? diff[31:0] : shf_r;
          done_r  <= 1'b1;
          state_r <= A_IDLE;
        end
        A_SQRT: begin
          // Bring down two radicand bits, try root*4+1
          rem_r  <= fits ? diff[31:0] : min_op[31:0];
          root_r <= root_nxt;
          shf_r  <= {shf_r[29:0], 2'b00};
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            res_r   <= {16'd0, root_nxt};
            done_r  <= 1'b1;
            state_r <= A_IDLE;
          end
        end
        default: begin
          state_r <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule
